### rtl/hrrp_pkg.sv
package hrrp_pkg;

    localparam int TOKEN_SLOTS  = 1024;
    localparam int MAX_NODES    = 64;
    localparam int MAX_REPLICAS = 8;

    localparam int SLOT_W  = $clog2(TOKEN_SLOTS);
    localparam int TC_W    = 11;
    localparam int NC_W    = 7;
    localparam int REP_W   = 4;
    localparam int OWNER_W = 6;
    localparam int HASH_W  = 64;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'd14695981039346656037;
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [HASH_W-1:0] MIX_MUL   = 64'hd6e8feb86659fd93;

    typedef enum logic [KIND_W-1:0] {
        KIND_TOKEN = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOKEN_COUNT = 2'd0,
        CFG_NODE_COUNT  = 2'd1,
        CFG_REPLICATION = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FNV_MUL,
        S_FIN_MUL,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_WALK_RD,
        S_WALK_CMP,
        S_FLUSH,
        S_ERR
    } t_state;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] p;
    } t_mul_rsp;

endpackage

### rtl/hrrp_mul.sv
module hrrp_mul
    import hrrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [HASH_W-1:0] r_a, r_b, r_prod, r_acc;
    logic [1:0]        r_cnt;
    logic              r_busy, r_done;
    logic [31:0]       w_x, w_y;
    logic [HASH_W-1:0] w_prod;

    // low*low, low*high, high*low; the high*high term falls off the top
    always_comb begin
        case (r_cnt)
            2'd1:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            2'd2:    begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
        endcase
    end

    assign w_prod = 64'(w_x) * 64'(w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            r_prod <= w_prod;
            case (r_cnt)
                2'd0:    r_acc <= r_acc;
                2'd1:    r_acc <= r_prod;
                default: r_acc <= r_acc + {r_prod[31:0], 32'd0};
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

### rtl/hash_ring_replica_placement.sv
// Channel   Direction  Handshake                 Beat
// input     in         i_in_valid / o_in_stall   kind, key byte/last, token slot/value/owner
// result    out        o_out_valid / i_out_stall node index, key hash, no_nodes, last
// config    in         i_cfg_valid / o_cfg_ready register index, write data
//
// A token write goes straight into the ring table. A key byte runs the 64-bit FNV multiply
// as three 32x32 partial products on one shared multiplier. A key end adds the finalizer
// multiply, then a read and a compare per token scanned for the lower bound and per token
// walked, since the ring table has one registered read port, and a flush state to hand off
// the final result. The input stalls meanwhile.
// Reset (synchronous, active low) resets control and config; the ring table is not cleared.
// A stalled result holds; a walk step that must push a result waits for the output register.
module hash_ring_replica_placement
    import hrrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [7:0]            i_key_byte,
    input  logic                  i_key_last,
    input  logic [SLOT_W-1:0]     i_token_slot,
    input  logic [HASH_W-1:0]     i_token_value,
    input  logic [OWNER_W-1:0]    i_token_owner,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OWNER_W-1:0]    o_node_index,
    output logic [HASH_W-1:0]     o_key_hash,
    output logic                  o_no_nodes,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic logic [HASH_W-1:0] fold(input logic [HASH_W-1:0] h);
        fold = h ^ (h >> 32);
    endfunction

    // Ring table: {value, owner} per slot
    logic [HASH_W+OWNER_W-1:0] r_mem [TOKEN_SLOTS];
    logic [HASH_W+OWNER_W-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [TC_W-1:0]    r_token_count;
    logic [NC_W-1:0]    r_node_count;
    logic [REP_W-1:0]   r_replication;

    logic [HASH_W-1:0]  r_acc_h, n_acc_h;
    logic               r_key_end, n_key_end;
    logic [HASH_W-1:0]  r_hash, n_hash;
    logic [TC_W-1:0]    r_tc, n_tc;
    logic [REP_W-1:0]   r_wanted, n_wanted;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [TC_W-1:0]    r_i, n_i;
    logic [REP_W-1:0]   r_n, n_n;
    logic [MAX_NODES-1:0] r_chosen, n_chosen;
    logic [OWNER_W-1:0] r_pend, n_pend;
    logic               r_have_pend, n_have_pend;

    logic               r_out_valid, n_out_valid;
    logic [OWNER_W-1:0] r_out_node, n_out_node;
    logic [HASH_W-1:0]  r_out_hash, n_out_hash;
    logic               r_out_err, n_out_err;
    logic               r_out_last, n_out_last;

    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    logic               w_in_acc, w_out_free;
    logic [TC_W-1:0]    w_tc_sat;
    logic [NC_W-1:0]    w_nc_sat;
    logic [REP_W-1:0]   w_rep_sat, w_wanted;
    logic               w_ring_empty;
    logic [OWNER_W-1:0] w_owner;
    logic               w_new, w_walk_go, w_walk_end, w_last_tok, w_ge;
    logic [REP_W-1:0]   w_n_next;

    hrrp_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mul_req),
        .o_rsp  (w_mul_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Clamp oversized registers, treat zero replication as one
    assign w_tc_sat  = (r_token_count > TC_W'(TOKEN_SLOTS)) ? TC_W'(TOKEN_SLOTS)
                                                             : r_token_count;
    assign w_nc_sat  = (r_node_count > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : r_node_count;
    always_comb begin
        if (r_replication == '0)
            w_rep_sat = REP_W'(1);
        else if (r_replication > REP_W'(MAX_REPLICAS))
            w_rep_sat = REP_W'(MAX_REPLICAS);
        else
            w_rep_sat = r_replication;
    end
    assign w_wanted     = (NC_W'(w_rep_sat) < w_nc_sat) ? w_rep_sat : w_nc_sat[REP_W-1:0];
    assign w_ring_empty = (w_nc_sat == '0) || (w_tc_sat == '0);

    assign w_owner    = r_rd_data[OWNER_W-1:0];
    assign w_ge       = (r_rd_data[HASH_W+OWNER_W-1:OWNER_W] >= r_hash);
    assign w_last_tok = (TC_W'(r_idx) == r_tc - TC_W'(1));
    assign w_new      = !r_chosen[w_owner];
    // a new owner pushes the pending one out, so it needs the output register
    assign w_walk_go  = !(w_new && r_have_pend) || w_out_free;
    assign w_n_next   = r_n + (w_new ? REP_W'(1) : REP_W'(0));
    assign w_walk_end = (w_n_next == r_wanted) || (r_i == r_tc - TC_W'(1));

    // Multiplier requests: FNV step on a byte, finalizer on key end
    always_comb begin
        w_mul_req.start = 1'b0;
        w_mul_req.a     = fold(r_acc_h);
        w_mul_req.b     = MIX_MUL;
        if (r_state == S_IDLE && w_in_acc && i_kind == KIND_BYTE) begin
            w_mul_req.start = 1'b1;
            w_mul_req.a     = r_acc_h ^ HASH_W'(i_key_byte);
            w_mul_req.b     = FNV_PRIME;
        end else if (r_state == S_IDLE && w_in_acc && i_kind == KIND_END) begin
            w_mul_req.start = 1'b1;
        end else if (r_state == S_FNV_MUL && w_mul_rsp.done && r_key_end) begin
            w_mul_req.start = 1'b1;
            w_mul_req.a     = fold(w_mul_rsp.p);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_kind)
                        KIND_BYTE: n_state = S_FNV_MUL;
                        KIND_END:  n_state = S_FIN_MUL;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_FNV_MUL: begin
                if (w_mul_rsp.done)
                    n_state = r_key_end ? S_FIN_MUL : S_IDLE;
            end
            S_FIN_MUL: begin
                if (w_mul_rsp.done)
                    n_state = w_ring_empty ? S_ERR : S_SCAN_RD;
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: n_state = (w_ge || w_last_tok) ? S_WALK_RD : S_SCAN_RD;
            S_WALK_RD:  n_state = S_WALK_CMP;
            S_WALK_CMP: begin
                if (w_walk_go)
                    n_state = w_walk_end ? S_FLUSH : S_WALK_RD;
            end
            S_FLUSH, S_ERR: begin
                if (w_out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result register
    always_comb begin
        n_acc_h     = r_acc_h;
        n_key_end   = r_key_end;
        n_hash      = r_hash;
        n_tc        = r_tc;
        n_wanted    = r_wanted;
        n_idx       = r_idx;
        n_i         = r_i;
        n_n         = r_n;
        n_chosen    = r_chosen;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_node  = r_out_node;
        n_out_hash  = r_out_hash;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_kind == KIND_BYTE) begin
                    n_key_end = i_key_last;
                end else if (w_in_acc && i_kind == KIND_END) begin
                    n_acc_h = FNV_BASIS;
                end
            end
            S_FNV_MUL: begin
                if (w_mul_rsp.done)
                    n_acc_h = r_key_end ? FNV_BASIS : w_mul_rsp.p;
            end
            S_FIN_MUL: begin
                if (w_mul_rsp.done) begin
                    n_hash   = fold(w_mul_rsp.p);
                    n_tc     = w_tc_sat;
                    n_wanted = w_wanted;
                    n_idx    = '0;
                end
            end
            S_SCAN_CMP: begin
                if (w_ge || w_last_tok) begin
                    // wrap to slot 0 when nothing is at or above the hash
                    if (!w_ge)
                        n_idx = '0;
                    n_i         = '0;
                    n_n         = '0;
                    n_chosen    = '0;
                    n_have_pend = 1'b0;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_WALK_CMP: begin
                if (w_walk_go) begin
                    if (w_new) begin
                        n_chosen    = r_chosen | (MAX_NODES'(1) << w_owner);
                        n_pend      = w_owner;
                        n_have_pend = 1'b1;
                        n_n         = w_n_next;
                        if (r_have_pend) begin
                            n_out_valid = 1'b1;
                            n_out_node  = r_pend;
                            n_out_hash  = r_hash;
                            n_out_err   = 1'b0;
                            n_out_last  = 1'b0;
                        end
                    end
                    if (!w_walk_end) begin
                        n_idx = w_last_tok ? '0 : r_idx + SLOT_W'(1);
                        n_i   = r_i + TC_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = r_pend;
                    n_out_hash  = r_hash;
                    n_out_err   = 1'b0;
                    n_out_last  = 1'b1;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = '0;
                    n_out_hash  = r_hash;
                    n_out_err   = 1'b1;
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_acc_h       <= FNV_BASIS;
            r_key_end     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_have_pend   <= 1'b0;
            r_n           <= '0;
            r_wanted      <= '0;
            r_chosen      <= '0;
            r_token_count <= '0;
            r_node_count  <= '0;
            r_replication <= REP_W'(1);
        end else begin
            r_state     <= n_state;
            r_acc_h     <= n_acc_h;
            r_key_end   <= n_key_end;
            r_out_valid <= n_out_valid;
            r_have_pend <= n_have_pend;
            r_n         <= n_n;
            r_wanted    <= n_wanted;
            r_chosen    <= n_chosen;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOKEN_COUNT: r_token_count <= i_cfg_data[TC_W-1:0];
                    CFG_NODE_COUNT:  r_node_count  <= i_cfg_data[NC_W-1:0];
                    CFG_REPLICATION: r_replication <= i_cfg_data[REP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash     <= n_hash;
        r_tc       <= n_tc;
        r_idx      <= n_idx;
        r_i        <= n_i;
        r_pend     <= n_pend;
        r_out_node <= n_out_node;
        r_out_hash <= n_out_hash;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    // Ring table: write on token beats, read the current slot every cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc && i_kind == KIND_TOKEN)
            r_mem[i_token_slot] <= {i_token_value, i_token_owner};
        r_rd_data <= r_mem[r_idx];
    end

    assign o_out_valid  = r_out_valid;
    assign o_node_index = r_out_node;
    assign o_key_hash   = r_out_hash;
    assign o_no_nodes   = r_out_err;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_last)
        else $error("error result without last");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> (r_state == S_FNV_MUL || r_state == S_FIN_MUL))
        else $error("multiplier finished outside a wait state");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_CMP || r_state == S_FLUSH) |-> r_n <= r_wanted)
        else $error("more replicas than wanted");
`endif

endmodule
